### rtl/pprms_pkg.sv
// Package for the per-point range mean / stddev unit.
// Holds widths, the channel word types, the controller command/status structs
// and shared constants.
`timescale 1ns / 1ps
package pprms_pkg;
  localparam int unsigned CoordW = 16;
  localparam int unsigned CntW   = 9;
  localparam int unsigned SumW   = 24;
  localparam int unsigned SqW    = 40;
  localparam int unsigned RngW   = 17;
  localparam int unsigned MagSqW = 35;
  localparam int unsigned NumW   = 49;
  localparam int unsigned OutW   = 16;

  typedef struct packed {
    logic signed [CoordW-1:0] x_mm;
    logic signed [CoordW-1:0] y_mm;
    logic signed [CoordW-1:0] z_mm;
    logic                     invalid;
    logic                     last_sample;
  } sample_t;

  typedef struct packed {
    logic [OutW-1:0] mean_mm;
    logic [OutW-1:0] stddev_mm;
    logic [CntW-1:0] valid_count;
    logic [CntW-1:0] nan_count;
    logic            no_valid;
  } stats_t;

  typedef struct packed {
    logic        load_sample;  // capture input word and start range root
    logic        root_step;    // one step of the shared root unit
    logic        accumulate;   // add range into sums
    logic        fin_start;    // start finishing math
    logic        div_step;     // one step of the shared divider
    logic        clear;        // clear point state
  } cmd_t;

  typedef struct packed {
    logic        root_done;
    logic        div_done;
    logic        fin_done;
    logic        is_last;
  } sts_t;
endpackage

### rtl/pprms_if.sv
// Valid/ready channel interface carrying a generic payload.
// Depends on nothing.
`timescale 1ns / 1ps
interface pprms_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/per_point_range_mean_stddev_unit.sv
// Per-point range mean / stddev unit, top level. One word at a time.
// An ordinary sample is accepted, then takes 25 root steps, a check that the root has
// finished and an accumulate step before ready rises again.
// A closing sample then runs two 49-step divisions (mean, then variance), each with a
// load step, and a final root of the variance quotient before its result is valid.
// Reset (async, active low) clears the sums, counts and controller.
`timescale 1ns / 1ps
module per_point_range_mean_stddev_unit #(
  parameter int unsigned MaxClouds = 256
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  pprms_if.sink   in_if,
  pprms_if.source out_if
);
  pprms_pkg::cmd_t cmd;
  pprms_pkg::sts_t sts;
  logic [pprms_pkg::OutW-1:0] mean_raw;

  pprms_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (in_if.valid), .in_ready_o (in_if.ready),
    .out_valid_o(out_if.valid), .out_ready_i(out_if.ready),
    .sts_i(sts), .cmd_o(cmd)
  );

  pprms_dp #(.MaxClouds(MaxClouds)) u_dp (
    .clk_i, .rst_ni,
    .x_mm_i(in_if.data.x_mm), .y_mm_i(in_if.data.y_mm), .z_mm_i(in_if.data.z_mm),
    .invalid_i(in_if.data.invalid), .last_sample_i(in_if.data.last_sample),
    .cmd_i(cmd), .sts_o(sts),
    .mean_mm_o(mean_raw), .stddev_mm_o(out_if.data.stddev_mm),
    .valid_count_o(out_if.data.valid_count), .nan_count_o(out_if.data.nan_count),
    .no_valid_o(out_if.data.no_valid)
  );

  assign out_if.data.mean_mm = out_if.data.no_valid ? '0 : mean_raw;
endmodule

### rtl/pprms_ctrl.sv
// Controller state machine for the per-point range unit.
// Depends on pprms_pkg.
`timescale 1ns / 1ps
module pprms_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  pprms_pkg::sts_t  sts_i,
  output pprms_pkg::cmd_t  cmd_o
);
  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StRoot  = 3'd1;
  localparam logic [2:0] StAcc   = 3'd2;
  localparam logic [2:0] StDiv   = 3'd3;
  localparam logic [2:0] StFin   = 3'd4;
  localparam logic [2:0] StOut   = 3'd5;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_sample = 1'b1;
          state_d = StRoot;
        end
      end
      StRoot: begin
        cmd_o.root_step = 1'b1;
        if (sts_i.root_done) state_d = StAcc;
      end
      StAcc: begin
        cmd_o.accumulate = 1'b1;
        if (sts_i.is_last) begin
          cmd_o.fin_start = 1'b1;
          state_d = StDiv;
        end else begin
          state_d = StIdle;
        end
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_done) state_d = StFin;
      end
      StFin: begin
        cmd_o.root_step = 1'b1;
        if (sts_i.fin_done) state_d = StOut;
      end
      StOut: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          cmd_o.clear = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= StIdle;
    else         state_q <= state_d;
  end
endmodule

### rtl/pprms_dp.sv
// Datapath: magnitudes, shared bit-serial square root, accumulators,
// shared restoring divider for mean and variance. Depends on pprms_pkg.
`timescale 1ns / 1ps
module pprms_dp #(
  parameter int unsigned MaxClouds = 256
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic signed [pprms_pkg::CoordW-1:0] x_mm_i,
  input  logic signed [pprms_pkg::CoordW-1:0] y_mm_i,
  input  logic signed [pprms_pkg::CoordW-1:0] z_mm_i,
  input  logic                            invalid_i,
  input  logic                            last_sample_i,
  input  pprms_pkg::cmd_t                 cmd_i,
  output pprms_pkg::sts_t                 sts_o,
  output logic [pprms_pkg::OutW-1:0]      mean_mm_o,
  output logic [pprms_pkg::OutW-1:0]      stddev_mm_o,
  output logic [pprms_pkg::CntW-1:0]      valid_count_o,
  output logic [pprms_pkg::CntW-1:0]      nan_count_o,
  output logic                            no_valid_o
);
  localparam int unsigned CntW = pprms_pkg::CntW;
  localparam int unsigned NumW = pprms_pkg::NumW;
  localparam int unsigned SumW = pprms_pkg::SumW;
  localparam int unsigned SqW  = pprms_pkg::SqW;
  localparam int unsigned RootW = 25;      // root of a 49-bit value
  localparam int unsigned RadW  = 2 * RootW;
  localparam logic [CntW-1:0] MaxCnt = CntW'(MaxClouds);

  logic [SumW-1:0] sum_q;
  logic [SqW-1:0]  sq_q;
  logic [CntW-1:0] good_q, bad_q;
  logic            sample_bad_q, last_q, take_q;

  // Shared root unit state (two bits of radicand per step).
  logic [RadW-1:0]  rad_q;
  logic [RootW+1:0] rem_q;
  logic [RootW-1:0] root_q;
  logic [4:0]       rstep_q;
  logic             root_done_q;

  // Shared divider state.
  logic [NumW-1:0]  dnum_q;
  logic [NumW-1:0]  dquo_q;
  logic [NumW:0]    drem_q;
  logic [17:0]      dden_q;
  logic [5:0]       dstep_q;
  logic             dphase_q;  // 0: mean, 1: variance
  logic             div_done_q;

  logic [16:0] ax, ay, az;
  logic [33:0] sx, sy, sz;
  logic [35:0] msq;
  always_comb begin
    ax = x_mm_i[15] ? 17'(-$signed({x_mm_i[15], x_mm_i})) : {1'b0, x_mm_i};
    ay = y_mm_i[15] ? 17'(-$signed({y_mm_i[15], y_mm_i})) : {1'b0, y_mm_i};
    az = z_mm_i[15] ? 17'(-$signed({z_mm_i[15], z_mm_i})) : {1'b0, z_mm_i};
    sx = {17'b0, ax} * {17'b0, ax};
    sy = {17'b0, ay} * {17'b0, ay};
    sz = {17'b0, az} * {17'b0, az};
    msq = 36'(sx) + 36'(sy) + 36'(sz);
  end

  // Root step: bring in two bits, try subtracting 4*root+1.
  logic [RootW+1:0] rem_sh;
  logic [RootW+1:0] trial;
  always_comb begin
    rem_sh = {rem_q[RootW-1:0], rad_q[RadW-1 -: 2]};
    trial  = {root_q, 2'b01};
  end

  // Square of the range; the range never exceeds 17 bits.
  logic [33:0] rng_sq;
  always_comb rng_sq = {17'b0, root_q[16:0]} * {17'b0, root_q[16:0]};

  // n*sq and sum^2 for the variance numerator.
  logic [NumW-1:0] a_prod, b_prod, vnum;
  always_comb begin
    a_prod = NumW'(sq_q) * NumW'(good_q);
    b_prod = NumW'(sum_q) * NumW'(sum_q);
    vnum   = (a_prod > b_prod) ? a_prod - b_prod : '0;
  end

  logic [NumW:0] dtrial;
  always_comb dtrial = {drem_q[NumW-1:0], dnum_q[NumW-1]};

  logic stop_acc;
  assign stop_acc = (10'(good_q) + 10'(bad_q)) >= 10'(MaxCnt);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0; sq_q <= '0; good_q <= '0; bad_q <= '0;
      rstep_q <= '0; root_done_q <= 1'b0; dstep_q <= '0;
      dphase_q <= 1'b0; div_done_q <= 1'b0; last_q <= 1'b0;
      sample_bad_q <= 1'b0; take_q <= 1'b0;
      rad_q <= '0; rem_q <= '0; root_q <= '0;
      dnum_q <= '0; dquo_q <= '0; drem_q <= '0; dden_q <= '0;
      mean_mm_o <= '0;
    end else begin
      if (cmd_i.load_sample) begin
        rad_q    <= RadW'(msq);
        rem_q    <= '0;
        root_q   <= '0;
        rstep_q  <= '0;
        root_done_q <= 1'b0;
        sample_bad_q <= invalid_i;
        last_q   <= last_sample_i;
        take_q   <= !stop_acc;
      end
      if (cmd_i.root_step && !root_done_q) begin
        rad_q <= {rad_q[RadW-3:0], 2'b00};
        if (rem_sh >= trial) begin
          rem_q  <= rem_sh - trial;
          root_q <= {root_q[RootW-2:0], 1'b1};
        end else begin
          rem_q  <= rem_sh;
          root_q <= {root_q[RootW-2:0], 1'b0};
        end
        rstep_q <= rstep_q + 5'd1;
        if (rstep_q == 5'(RootW - 1)) root_done_q <= 1'b1;
      end
      if (cmd_i.accumulate && take_q) begin
        if (sample_bad_q) begin
          bad_q <= bad_q + 9'd1;
        end else begin
          sum_q  <= sum_q + SumW'(root_q);
          sq_q   <= sq_q + SqW'(rng_sq);
          good_q <= good_q + 9'd1;
        end
      end
      if (cmd_i.fin_start) begin
        // Sums are updated this same edge; the divider starts next cycle.
        dstep_q    <= '0;
        dphase_q   <= 1'b0;
        div_done_q <= 1'b0;
        dden_q     <= '0;
      end
      if (cmd_i.div_step && !div_done_q) begin
        if (dstep_q == 6'd0 && dden_q == '0) begin
          // Load the mean division first, then the variance division.
          dnum_q <= dphase_q ? vnum : NumW'(sum_q);
          dden_q <= dphase_q ? 18'(good_q) * 18'(good_q) : 18'(good_q);
          drem_q <= '0;
          dquo_q <= '0;
          dstep_q <= 6'd1;
        end else begin
          dnum_q <= {dnum_q[NumW-2:0], 1'b0};
          if (dtrial >= (NumW+1)'(dden_q)) begin
            drem_q <= dtrial - (NumW+1)'(dden_q);
            dquo_q <= {dquo_q[NumW-2:0], 1'b1};
          end else begin
            drem_q <= dtrial;
            dquo_q <= {dquo_q[NumW-2:0], 1'b0};
          end
          dstep_q <= dstep_q + 6'd1;
          if (dstep_q == 6'(NumW)) begin
            dstep_q <= '0;
            if (!dphase_q) begin
              mean_mm_o <= {dquo_q[14:0], (dtrial >= (NumW+1)'(dden_q))};
              dphase_q <= 1'b1;
              dden_q   <= '0;
            end else begin
              div_done_q  <= 1'b1;
              rad_q       <= RadW'({dquo_q[NumW-2:0],
                                    (dtrial >= (NumW+1)'(dden_q))});
              rem_q       <= '0;
              root_q      <= '0;
              rstep_q     <= '0;
              root_done_q <= 1'b0;
            end
          end
        end
      end
      if (cmd_i.clear) begin
        sum_q <= '0; sq_q <= '0; good_q <= '0; bad_q <= '0;
      end
    end
  end

  // A zero divisor (no valid sample) divides to all ones; outputs mask it.
  assign stddev_mm_o   = (good_q == '0) ? '0 : root_q[15:0];
  assign valid_count_o = good_q;
  assign nan_count_o   = bad_q;
  assign no_valid_o    = (good_q == '0);

  assign sts_o.root_done = root_done_q;
  assign sts_o.div_done  = div_done_q;
  assign sts_o.fin_done  = root_done_q;
  assign sts_o.is_last   = last_q;
endmodule

### tb/sv/tb.sv
// Testbench for per_point_range_mean_stddev_unit: random and directed samples in,
// per-point results checked against an in-bench predictor of the range statistics.
// Depends on rtl/pprms_pkg.sv, rtl/pprms_if.sv and the unit's top level.
`timescale 1ns / 1ps
module tb;
  localparam int unsigned CoordW = pprms_pkg::CoordW;
  localparam int unsigned OutW   = pprms_pkg::OutW;
  localparam int unsigned CntW   = pprms_pkg::CntW;
  localparam int unsigned SumW   = pprms_pkg::SumW;
  localparam int unsigned SqW    = pprms_pkg::SqW;

  localparam int unsigned Clouds = 256;
  localparam int unsigned CycleLimit = 3000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #1 clk_i = ~clk_i;

  pprms_if #(.payload_t(pprms_pkg::sample_t)) in_if ();
  pprms_if #(.payload_t(pprms_pkg::stats_t))  out_if ();

  per_point_range_mean_stddev_unit #(.MaxClouds(Clouds)) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_if (in_if),
    .out_if(out_if)
  );

  pprms_pkg::sample_t pending_samples[$];
  pprms_pkg::stats_t  expected_stats[$];
  int unsigned mismatches = 0;
  int unsigned points_seen = 0;
  int unsigned cycle = 0;

  // Predictor state for the point currently being accumulated.
  logic [SumW-1:0] acc_sum;
  logic [SqW-1:0]  acc_sq;
  logic [CntW-1:0] acc_good;
  logic [CntW-1:0] acc_bad;

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] root;
    logic [63:0] bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v = v - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic logic [63:0] magnitude(input logic signed [CoordW-1:0] c);
    logic [63:0] w;
    w = 64'(c);
    if (c < 0) w = -w;
    return w & 64'hFFFF_FFFF;
  endfunction

  task automatic predict_sample(input pprms_pkg::sample_t s);
    logic [63:0] r, n, a, b, num;
    pprms_pkg::stats_t e;
    if (32'(acc_good) + 32'(acc_bad) < Clouds) begin
      if (s.invalid) begin
        acc_bad = acc_bad + 9'd1;
      end else begin
        r = int_sqrt(magnitude(s.x_mm) ** 2 + magnitude(s.y_mm) ** 2
                     + magnitude(s.z_mm) ** 2);
        acc_sum = SumW'(64'(acc_sum) + r);
        acc_sq  = SqW'(64'(acc_sq) + r * r);
        acc_good = acc_good + 9'd1;
      end
    end
    if (s.last_sample) begin
      n = 64'(acc_good);
      e = '0;
      if (n != 0) begin
        a = n * 64'(acc_sq);
        b = 64'(acc_sum) * 64'(acc_sum);
        num = (a > b) ? a - b : 0;
        e.mean_mm = OutW'(64'(acc_sum) / n);
        e.stddev_mm = OutW'(int_sqrt(num / (n * n)));
      end
      e.valid_count = acc_good;
      e.nan_count = acc_bad;
      e.no_valid = (n == 0);
      expected_stats.insert(expected_stats.size(), e);
      acc_sum = '0;
      acc_sq = '0;
      acc_good = '0;
      acc_bad = '0;
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    $display("mismatch at point %0d: %s got %0d expected %0d", points_seen, what, got, want);
  endtask

  // No idling during a long window in the middle of the run.
  function automatic bit take_break();
    if (cycle > 30000 && cycle < 90000) return 1'b0;
    return $urandom_range(99) < 32;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_if.data  <= '0;
    end else begin
      if (in_if.valid && in_if.ready) predict_sample(in_if.data);
      if (!in_if.valid || in_if.ready) begin
        if (pending_samples.size() != 0 && !take_break()) begin
          in_if.valid <= 1'b1;
          in_if.data  <= pending_samples.pop_front();
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_stats.size() == 0) begin
          report_mismatch("unexpected word", 1, 0);
        end else begin
          pprms_pkg::stats_t e;
          e = expected_stats.pop_front();
          if (out_if.data.mean_mm !== e.mean_mm)
            report_mismatch("mean_mm", 32'(out_if.data.mean_mm), 32'(e.mean_mm));
          if (out_if.data.stddev_mm !== e.stddev_mm)
            report_mismatch("stddev_mm", 32'(out_if.data.stddev_mm), 32'(e.stddev_mm));
          if (out_if.data.valid_count !== e.valid_count)
            report_mismatch("valid_count", 32'(out_if.data.valid_count),
                            32'(e.valid_count));
          if (out_if.data.nan_count !== e.nan_count)
            report_mismatch("nan_count", 32'(out_if.data.nan_count), 32'(e.nan_count));
          if (out_if.data.no_valid !== e.no_valid)
            report_mismatch("no_valid", 32'(out_if.data.no_valid), 32'(e.no_valid));
        end
        points_seen++;
      end
      out_if.ready <= !take_break();
    end
  end

  always @(posedge clk_i) begin
    cycle <= cycle + 1;
    if (cycle > CycleLimit) begin
      $display("timeout with %0d results outstanding", expected_stats.size());
      $display("tb NOT OK");
      $finish;
    end
  end

  task automatic add_sample(input logic [15:0] x, input logic [15:0] y,
                            input logic [15:0] z, input bit inv, input bit last);
    pprms_pkg::sample_t s;
    s.x_mm = x;
    s.y_mm = y;
    s.z_mm = z;
    s.invalid = inv;
    s.last_sample = last;
    pending_samples.insert(pending_samples.size(), s);
  endtask

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'(int'($urandom_range(200)) - 100);
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    int unsigned total;
    int unsigned len;
    bit broken;
    acc_sum = '0;
    acc_sq = '0;
    acc_good = '0;
    acc_bad = '0;

    // Directed: extremes, a point of one sample, an all-invalid point, and
    // ignored coordinates on an invalid sample.
    add_sample(16'h8000, 16'h8000, 16'h8000, 0, 1);
    add_sample(16'h7FFF, 16'h7FFF, 16'h7FFF, 0, 0);
    add_sample(16'h0000, 16'h0000, 16'h0000, 0, 1);
    add_sample(16'h8000, 16'h7FFF, 16'h8000, 1, 0);
    add_sample(16'hFFFF, 16'h0001, 16'h1234, 1, 1);
    add_sample(16'd3, 16'd4, 16'd0, 0, 0);
    add_sample(16'd3, 16'd4, 16'd0, 0, 0);
    add_sample(16'h7FFF, 16'h7FFF, 16'h7FFF, 1, 1);
    add_sample(16'h8000, 16'h0000, 16'h0000, 0, 0);
    add_sample(16'h0000, 16'h0000, 16'h0000, 0, 0);
    add_sample(16'h0000, 16'h8000, 16'h7FFF, 0, 1);
    // A point that reaches the cloud limit exactly, then one that runs past it.
    for (int i = 0; i < Clouds; i++)
      add_sample(rand_coord(), rand_coord(), rand_coord(), i % 5 == 0, i == Clouds - 1);
    for (int i = 0; i < Clouds + 6; i++)
      add_sample(rand_coord(), rand_coord(), rand_coord(), i > Clouds, i == Clouds + 5);
    total = pending_samples.size();

    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (total < 1250) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
      broken = $urandom_range(9) == 0;
      for (int i = 0; i < len; i++)
        add_sample(rand_coord(), rand_coord(), rand_coord(),
                   broken ? 1'b1 : ($urandom_range(5) == 0), i == len - 1);
      total += len;
    end

    while (pending_samples.size() != 0 || in_if.valid || expected_stats.size() != 0)
      @(posedge clk_i);
    repeat (400) @(posedge clk_i);
    $display("checked %0d points from %0d random and directed samples,",
             points_seen, total);
    $display("including all-invalid points and points past the cloud limit");
    if (mismatches == 0 && expected_stats.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end
endmodule
